/* rtl/bac_pkg.sv */
package bac_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET_TIME  = 3'd1,
    OP_SET_ALARM = 3'd2,
    OP_ALARM_OFF = 3'd3,
    OP_SNOOZE    = 3'd4
  } op_e;

  // Alarm modes
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_READY  = 2'd1,
    MODE_RING   = 2'd2,
    MODE_SNOOZE = 2'd3
  } mode_e;

  // Digit positions, tens of hours first
  localparam int unsigned POS_TH = 0;
  localparam int unsigned POS_UH = 1;
  localparam int unsigned POS_TM = 2;
  localparam int unsigned POS_UM = 3;
  localparam int unsigned POS_TS = 4;
  localparam int unsigned POS_US = 5;

  localparam logic [3:0] DIGIT_UNSET     = 4'hF;
  localparam logic [3:0] DIGIT_MAX       = 4'd9;
  localparam logic [3:0] TENS_MAX        = 4'd5;
  localparam logic [3:0] HOUR_TENS_MAX   = 4'd2;
  localparam logic [3:0] HOUR_UNITS_LAST = 4'd3;
  localparam logic [13:0] SECS_PER_MIN   = 14'd60;
  localparam logic [23:0] TPS_RESET      = 24'd999;

  // Six time digits and four alarm digits, index 0 in the low bits
  typedef logic [5:0][3:0] time_t;
  typedef logic [3:0][3:0] alarm_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] tens_hour;
    logic [3:0] units_hour;
    logic [3:0] tens_minute;
    logic [3:0] units_minute;
    logic [3:0] tens_second;
    logic [3:0] units_second;
    logic [7:0] snooze_minutes;
  } in_t;

  typedef struct packed {
    logic [3:0] shown_tens_hour;
    logic [3:0] shown_units_hour;
    logic [2:0] shown_tens_minute;
    logic [3:0] shown_units_minute;
    logic [2:0] shown_tens_second;
    logic [3:0] shown_units_second;
    logic       time_valid;
    logic [1:0] alarm_state;
    logic       alarm_ring;
    logic       second_pulse;
    logic       accepted;
  } out_t;

endpackage

/* rtl/bcd_alarm_clock_top.sv */
// An item taken in waits in the input register and moves on into the result register
// once that is free or being drained. One item per cycle unless the output stalls; the
// clock state updates on that move, so each item sees the state left by the last one.
// Reset (asynchronous, active low): clock unset (tens of hours 15), alarm off,
// prescaler and snooze count zero, prescaler limit 999, both stages empty.
module bcd_alarm_clock_top #(
  parameter int unsigned PRESCALE_WIDTH = 24,
  parameter int unsigned SNOOZE_WIDTH   = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [23:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bac_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bac_pkg::out_t out_data_o
);

  logic [23:0]               tps_q;
  logic [31:0]               tps_ext;
  logic [PRESCALE_WIDTH-1:0] limit;

  logic                      in_valid_q, in_valid_d;
  bac_pkg::in_t              in_q;
  logic                      out_valid_q, out_valid_d;
  bac_pkg::out_t             out_q;
  logic                      advance;
  logic                      in_take;

  bac_pkg::time_t            time_q, time_d;
  bac_pkg::alarm_t           alarm_q, alarm_d;
  logic [PRESCALE_WIDTH-1:0] presc_q, presc_d;
  bac_pkg::mode_e            mode_q, mode_d;
  logic [SNOOZE_WIDTH-1:0]   snooze_q, snooze_d;
  bac_pkg::out_t             result;

  // Prescaler limit register, masked to the prescaler width
  assign cfg_ready_o = 1'b1;
  assign tps_ext     = 32'(tps_q);
  assign limit       = tps_ext[PRESCALE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= bac_pkg::TPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tps_q <= cfg_data_i;
    end
  end

  // Move the held item on when the result register is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payloads
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  bac_clock_core #(
    .PRESCALE_WIDTH(PRESCALE_WIDTH),
    .SNOOZE_WIDTH  (SNOOZE_WIDTH)
  ) u_core (
    .item_i  (in_q),
    .limit_i (limit),
    .time_i  (time_q),
    .alarm_i (alarm_q),
    .presc_i (presc_q),
    .mode_i  (mode_q),
    .snooze_i(snooze_q),
    .time_o  (time_d),
    .alarm_o (alarm_d),
    .presc_o (presc_d),
    .mode_o  (mode_d),
    .snooze_o(snooze_d),
    .result_o(result)
  );

  // Commit the clock state with each transfer into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // tens of hours sits in the lowest digit
      time_q   <= {20'd0, bac_pkg::DIGIT_UNSET};
      alarm_q  <= '0;
      presc_q  <= '0;
      mode_q   <= bac_pkg::MODE_OFF;
      snooze_q <= '0;
    end else if (advance) begin
      time_q   <= time_d;
      alarm_q  <= alarm_d;
      presc_q  <= presc_d;
      mode_q   <= mode_d;
      snooze_q <= snooze_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A held item with a free output side lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_stall_i |=> out_valid_o)
    else $error("held item did not reach the result register");

  // Input stalls only behind a stalled, full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without back-pressure");

  // Any alarm mode other than off needs a set clock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.alarm_state != bac_pkg::MODE_OFF) |-> out_data_o.time_valid)
    else $error("alarm active on an unset clock");
`endif

endmodule

/* rtl/bac_clock_core.sv */
module bac_clock_core #(
  parameter int unsigned PRESCALE_WIDTH = 24,
  parameter int unsigned SNOOZE_WIDTH   = 16
) (
  input  bac_pkg::in_t              item_i,
  input  logic [PRESCALE_WIDTH-1:0] limit_i,
  input  bac_pkg::time_t            time_i,
  input  bac_pkg::alarm_t           alarm_i,
  input  logic [PRESCALE_WIDTH-1:0] presc_i,
  input  bac_pkg::mode_e            mode_i,
  input  logic [SNOOZE_WIDTH-1:0]   snooze_i,
  output bac_pkg::time_t            time_o,
  output bac_pkg::alarm_t           alarm_o,
  output logic [PRESCALE_WIDTH-1:0] presc_o,
  output bac_pkg::mode_e            mode_o,
  output logic [SNOOZE_WIDTH-1:0]   snooze_o,
  output bac_pkg::out_t             result_o
);

  localparam int unsigned SumW = SNOOZE_WIDTH + 1;
  localparam logic [PRESCALE_WIDTH-1:0] PrescOne = PRESCALE_WIDTH'(1);
  localparam logic [SNOOZE_WIDTH-1:0] SnoozeOne = SNOOZE_WIDTH'(1);

  bac_pkg::time_t            item_dig;
  bac_pkg::time_t            adv;
  logic [5:0]                can;
  logic [5:0]                carry;
  logic                      run;
  logic                      clock_set;
  logic                      time_ok;
  logic [13:0]               snz_add;
  logic [SumW-1:0]           snz_sum;
  logic [SNOOZE_WIDTH-1:0]   snz_sat;
  logic                      pulse;
  logic                      acc;

  // Gather the digit fields of the item
  assign item_dig[bac_pkg::POS_TH] = item_i.tens_hour;
  assign item_dig[bac_pkg::POS_UH] = item_i.units_hour;
  assign item_dig[bac_pkg::POS_TM] = item_i.tens_minute;
  assign item_dig[bac_pkg::POS_UM] = item_i.units_minute;
  assign item_dig[bac_pkg::POS_TS] = item_i.tens_second;
  assign item_dig[bac_pkg::POS_US] = item_i.units_second;

  assign clock_set = (time_i[bac_pkg::POS_TH] <= bac_pkg::HOUR_TENS_MAX);
  assign run       = !(time_i[bac_pkg::POS_TH] > bac_pkg::DIGIT_MAX);

  // Which digits can step without carrying on
  assign can[bac_pkg::POS_US] = time_i[bac_pkg::POS_US] < bac_pkg::DIGIT_MAX;
  assign can[bac_pkg::POS_TS] = time_i[bac_pkg::POS_TS] < bac_pkg::TENS_MAX;
  assign can[bac_pkg::POS_UM] = time_i[bac_pkg::POS_UM] < bac_pkg::DIGIT_MAX;
  assign can[bac_pkg::POS_TM] = time_i[bac_pkg::POS_TM] < bac_pkg::TENS_MAX;
  assign can[bac_pkg::POS_UH] = (time_i[bac_pkg::POS_TH] < bac_pkg::HOUR_TENS_MAX)
                              ? (time_i[bac_pkg::POS_UH] < bac_pkg::DIGIT_MAX)
                              : (time_i[bac_pkg::POS_UH] < bac_pkg::HOUR_UNITS_LAST);
  assign can[bac_pkg::POS_TH] = time_i[bac_pkg::POS_TH] < bac_pkg::HOUR_TENS_MAX;

  // Ripple the carry from units of seconds up to tens of hours
  always_comb begin
    carry[bac_pkg::POS_US] = 1'b1;
    for (int k = 4; k >= 0; k--) begin
      carry[k] = carry[k+1] && !can[k+1];
    end
  end

  // Step the digit that takes the carry and clear those below it
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (carry[k]) begin
        adv[k] = can[k] ? (time_i[k] + 4'd1) : 4'd0;
      end else begin
        adv[k] = time_i[k];
      end
    end
  end

  // Check a set-time request
  assign time_ok = (item_dig[bac_pkg::POS_TH] <= bac_pkg::HOUR_TENS_MAX)
                && (item_dig[bac_pkg::POS_UH] <= bac_pkg::DIGIT_MAX)
                && ((item_dig[bac_pkg::POS_TH] < bac_pkg::HOUR_TENS_MAX)
                    || (item_dig[bac_pkg::POS_UH] <= bac_pkg::HOUR_UNITS_LAST))
                && (item_dig[bac_pkg::POS_TM] <= bac_pkg::TENS_MAX)
                && (item_dig[bac_pkg::POS_UM] <= bac_pkg::DIGIT_MAX)
                && (item_dig[bac_pkg::POS_TS] <= bac_pkg::TENS_MAX)
                && (item_dig[bac_pkg::POS_US] <= bac_pkg::DIGIT_MAX);

  // Add snooze minutes as seconds, saturating
  assign snz_add = {6'd0, item_i.snooze_minutes} * bac_pkg::SECS_PER_MIN;
  assign snz_sum = {1'b0, snooze_i} + SumW'(snz_add);
  assign snz_sat = snz_sum[SNOOZE_WIDTH] ? {SNOOZE_WIDTH{1'b1}} : snz_sum[SNOOZE_WIDTH-1:0];

  // Next state for one item
  always_comb begin
    time_o   = time_i;
    alarm_o  = alarm_i;
    presc_o  = presc_i;
    mode_o   = mode_i;
    snooze_o = snooze_i;
    pulse    = 1'b0;
    acc      = 1'b0;
    case (bac_pkg::op_e'(item_i.operation))
      bac_pkg::OP_TICK: begin
        if (presc_i >= limit_i) begin
          presc_o = '0;
          pulse   = 1'b1;
          if (run) begin
            if (mode_i == bac_pkg::MODE_SNOOZE) begin
              if (snooze_i[SNOOZE_WIDTH-1:1] == '0) begin
                snooze_o = '0;
                if (clock_set) begin
                  mode_o = bac_pkg::MODE_RING;
                end
              end else begin
                snooze_o = snooze_i - SnoozeOne;
              end
            end
            time_o = adv;
            // compare HH:MM with the alarm when the minute changes
            if (carry[bac_pkg::POS_UM] && (mode_o == bac_pkg::MODE_READY)
                && (alarm_i == adv[3:0])
                && (adv[bac_pkg::POS_TH] <= bac_pkg::HOUR_TENS_MAX)) begin
              mode_o = bac_pkg::MODE_RING;
            end
          end
        end else begin
          presc_o = presc_i + PrescOne;
        end
      end
      bac_pkg::OP_SET_TIME: begin
        acc = time_ok;
        if (time_ok) begin
          time_o = item_dig;
        end
      end
      bac_pkg::OP_SET_ALARM: begin
        alarm_o = item_dig[3:0];
        acc     = clock_set;
        if (clock_set) begin
          mode_o = bac_pkg::MODE_READY;
        end
      end
      bac_pkg::OP_ALARM_OFF: begin
        acc = clock_set;
        if (clock_set) begin
          mode_o = bac_pkg::MODE_READY;
        end
      end
      bac_pkg::OP_SNOOZE: begin
        snooze_o = snz_sat;
        acc      = clock_set;
        if (clock_set) begin
          mode_o = bac_pkg::MODE_SNOOZE;
        end
      end
      default: begin
      end
    endcase
  end

  // Build the result from the state after the item
  always_comb begin
    result_o.shown_tens_hour    = time_o[bac_pkg::POS_TH];
    result_o.shown_units_hour   = time_o[bac_pkg::POS_UH];
    result_o.shown_tens_minute  = time_o[bac_pkg::POS_TM][2:0];
    result_o.shown_units_minute = time_o[bac_pkg::POS_UM];
    result_o.shown_tens_second  = time_o[bac_pkg::POS_TS][2:0];
    result_o.shown_units_second = time_o[bac_pkg::POS_US];
    result_o.time_valid         = (time_o[bac_pkg::POS_TH] <= bac_pkg::HOUR_TENS_MAX);
    result_o.alarm_state        = mode_o;
    result_o.alarm_ring         = (mode_o == bac_pkg::MODE_RING);
    result_o.second_pulse       = pulse;
    result_o.accepted           = acc;
  end

endmodule
